### src/srld_pkg.sv
// Shared types and constants for the sprite run-length decoder.
package srld_pkg;

  // Widths fixed by the stream and pixel formats
  localparam int unsigned PIX_IDX_W       = 10;
  localparam int unsigned CONSUMED_W      = 17;
  localparam int unsigned FRAME_PIXELS_DEF = 1024;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_FIRST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_IN   = 1'b1;

  // Command queue between parser and packer
  localparam int unsigned QUEUE_DEPTH = 2;

  // One result as produced by the parser, before byte ordering
  typedef struct packed {
    logic                 pixel_valid;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [7:0]           s0;
    logic [7:0]           s1;
    logic [7:0]           s2;
    logic [7:0]           alpha;
    logic                 record_done;
  } cmd_t;

endpackage

### src/srld_if.sv
// Valid/ready channel interfaces for the record byte stream and the pixel results.
interface srld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       record_start;

  modport source (output valid, output data_byte, output record_start, input ready);
  modport sink   (input valid, input data_byte, input record_start, output ready);
endinterface

interface srld_pixel_if;
  logic        valid;
  logic        ready;
  logic        pixel_valid;
  logic [9:0]  pixel_index;
  logic [31:0] pixel_word;
  logic        record_done;

  modport source (output valid, output pixel_valid, output pixel_index, output pixel_word,
                  output record_done, input ready);
  modport sink   (input valid, input pixel_valid, input pixel_index, input pixel_word,
                  input record_done, output ready);
endinterface

### src/srld_parse.sv
// Front end: accepts record bytes, tracks the record phase and raises pixel/done commands.
module srld_parse #(
  parameter int unsigned FRAME_PIXELS = srld_pkg::FRAME_PIXELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               alpha_in_stream,
  input  logic               queue_full,
  srld_byte_if.sink          in_ch,
  output logic               push,
  output srld_pkg::cmd_t     push_cmd
);
  import srld_pkg::*;

  localparam int unsigned WP_W = $clog2(FRAME_PIXELS + 1);
  localparam logic [WP_W-1:0] FRAME_POS = WP_W'(FRAME_PIXELS);
  localparam logic [CONSUMED_W-1:0] CONSUMED_MAX = {CONSUMED_W{1'b1}};

  typedef enum logic [9:0] {
    PH_WAIT = 10'b00_0000_0001,
    PH_KEY1 = 10'b00_0000_0010,
    PH_KEY2 = 10'b00_0000_0100,
    PH_SZLO = 10'b00_0000_1000,
    PH_SZHI = 10'b00_0001_0000,
    PH_SKLO = 10'b00_0010_0000,
    PH_SKHI = 10'b00_0100_0000,
    PH_CTLO = 10'b00_1000_0000,
    PH_CTHI = 10'b01_0000_0000,
    PH_PIX  = 10'b10_0000_0000
  } phase_t;

  phase_t                phase, phase_next;
  logic [15:0]           payload_size, payload_size_next;
  logic [CONSUMED_W-1:0] consumed, consumed_next;
  logic [WP_W-1:0]       wpos, wpos_next;
  logic [15:0]           pixels_left, pixels_left_next;
  logic [7:0]            low_hold, low_hold_next;
  logic [23:0]           colour_hold, colour_hold_next;
  logic [1:0]            cbyte, cbyte_next;

  logic                  accept;
  logic [15:0]           word16;
  logic [16:0]           skip_sum;
  logic [2:0]            cons_add;
  logic [CONSUMED_W:0]   cons_sum;
  logic [CONSUMED_W-1:0] cons_sat;
  logic                  complete;
  logic [15:0]           pl_dec;
  cmd_t                  cmd;
  logic                  has_result;

  // Take a byte whenever the queue has room
  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign word16      = {in_ch.data_byte, low_hold};
  assign skip_sum    = 17'(wpos) + 17'(word16);

  // Saturating payload byte count: a run header or an alpha pixel adds four, else three
  assign cons_add = (phase == PH_PIX && cbyte != 2'd3) ? 3'd3 : 3'd4;
  assign cons_sum = (CONSUMED_W+1)'(consumed) + (CONSUMED_W+1)'(cons_add);
  assign cons_sat = cons_sum[CONSUMED_W] ? CONSUMED_MAX : cons_sum[CONSUMED_W-1:0];
  assign pl_dec   = pixels_left - 16'd1;

  // Classify the byte and work out the next phase
  always_comb begin
    phase_next        = phase;
    payload_size_next = payload_size;
    consumed_next     = consumed;
    wpos_next         = wpos;
    pixels_left_next  = pixels_left;
    low_hold_next     = low_hold;
    colour_hold_next  = colour_hold;
    cbyte_next        = cbyte;
    complete          = 1'b0;
    cmd               = '0;

    if (accept && in_ch.record_start) begin
      phase_next        = PH_KEY1;
      payload_size_next = '0;
      consumed_next     = '0;
      wpos_next         = '0;
      pixels_left_next  = '0;
      low_hold_next     = '0;
      colour_hold_next  = '0;
      cbyte_next        = '0;
    end else if (accept) begin
      unique case (phase)
        PH_WAIT: phase_next = PH_WAIT;
        PH_KEY1: phase_next = PH_KEY2;
        PH_KEY2: phase_next = PH_SZLO;
        PH_SZLO: begin
          low_hold_next = in_ch.data_byte;
          phase_next    = PH_SZHI;
        end
        PH_SZHI: begin
          payload_size_next = word16;
          if (word16 == 16'd0) begin
            cmd.record_done = 1'b1;
            phase_next      = PH_WAIT;
          end else begin
            phase_next = PH_SKLO;
          end
        end
        PH_SKLO: begin
          low_hold_next = in_ch.data_byte;
          phase_next    = PH_SKHI;
        end
        PH_SKHI: begin
          // Advance past the transparent run, clamp at the frame end
          if (skip_sum > 17'(FRAME_PIXELS)) begin
            wpos_next = FRAME_POS;
          end else begin
            wpos_next = WP_W'(skip_sum);
          end
          phase_next = PH_CTLO;
        end
        PH_CTLO: begin
          low_hold_next = in_ch.data_byte;
          phase_next    = PH_CTHI;
        end
        PH_CTHI: begin
          pixels_left_next = word16;
          consumed_next    = cons_sat;
          cbyte_next       = '0;
          colour_hold_next = '0;
          if (word16 == 16'd0) begin
            cmd.record_done = (cons_sat >= CONSUMED_W'(payload_size));
            phase_next      = cmd.record_done ? PH_WAIT : PH_SKLO;
          end else begin
            phase_next = PH_PIX;
          end
        end
        PH_PIX: begin
          cmd.alpha = 8'hFF;
          if (cbyte != 2'd3) begin
            colour_hold_next = colour_hold | (24'(in_ch.data_byte) << {cbyte, 3'b000});
            if (cbyte == 2'd2 && !alpha_in_stream) begin
              complete = 1'b1;
            end else begin
              cbyte_next = cbyte + 2'd1;
            end
          end else begin
            cmd.alpha = in_ch.data_byte;
            complete  = 1'b1;
          end
          if (complete) begin
            consumed_next = cons_sat;
            // Emit only inside the frame; bytes past it are still consumed
            if (wpos < FRAME_POS) begin
              cmd.pixel_valid = 1'b1;
              cmd.pixel_index = PIX_IDX_W'(wpos);
              cmd.s0          = colour_hold_next[7:0];
              cmd.s1          = colour_hold_next[15:8];
              cmd.s2          = colour_hold_next[23:16];
              wpos_next       = wpos + WP_W'(1);
            end
            colour_hold_next = '0;
            cbyte_next       = '0;
            pixels_left_next = pl_dec;
            if (pl_dec == 16'd0) begin
              cmd.record_done = (cons_sat >= CONSUMED_W'(payload_size));
              phase_next      = cmd.record_done ? PH_WAIT : PH_SKLO;
            end
          end
          if (!cmd.pixel_valid) begin
            cmd.alpha = 8'h00;
          end
        end
        default: phase_next = PH_WAIT;
      endcase
    end
  end

  assign has_result = cmd.pixel_valid || cmd.record_done;
  assign push       = accept && !in_ch.record_start && has_result;
  assign push_cmd   = cmd;

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT;
      payload_size <= '0;
      consumed     <= '0;
      wpos         <= '0;
      pixels_left  <= '0;
      low_hold     <= '0;
      colour_hold  <= '0;
      cbyte        <= '0;
    end else begin
      phase        <= phase_next;
      payload_size <= payload_size_next;
      consumed     <= consumed_next;
      wpos         <= wpos_next;
      pixels_left  <= pixels_left_next;
      low_hold     <= low_hold_next;
      colour_hold  <= colour_hold_next;
      cbyte        <= cbyte_next;
    end
  end

endmodule

### src/srld_queue.sv
// Short command queue that lets the parser and the packer stall independently.
module srld_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  srld_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output srld_pkg::cmd_t  head
);
  import srld_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### src/srld_pack.sv
// Back end: orders pixel bytes and holds the result in the output register.
module srld_pack (
  input  logic            clk,
  input  logic            rst,
  input  logic            blue_first_order,
  input  logic            not_empty,
  input  srld_pkg::cmd_t  head,
  output logic            pop,
  srld_pixel_if.source    out_ch
);
  import srld_pkg::*;

  logic                 out_valid;
  logic                 pix_valid;
  logic [PIX_IDX_W-1:0] pix_index;
  logic [31:0]          pix_word;
  logic                 rec_done;
  logic [31:0]          word_next;

  // Load a new result when the register is empty or being drained
  assign pop = not_empty && (!out_valid || out_ch.ready);

  always_comb begin
    if (blue_first_order) begin
      word_next = {head.alpha, head.s0, head.s1, head.s2};
    end else begin
      word_next = {head.alpha, head.s2, head.s1, head.s0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pix_valid <= head.pixel_valid;
      pix_index <= head.pixel_index;
      pix_word  <= word_next;
      rec_done  <= head.record_done;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.pixel_valid = pix_valid;
  assign out_ch.pixel_index = pix_index;
  assign out_ch.pixel_word  = pix_word;
  assign out_ch.record_done = rec_done;

endmodule

### src/sprite_run_length_decoder.sv
// Sprite run-length decoder: one record byte per cycle in, one pixel/done result out.
// Throughput: one byte accepted every cycle while the output side keeps taking results.
// A result is registered in the command queue and then in the output register after its byte is accepted.
// A two-entry command queue between parser and packer absorbs output stalls.
// Reset (synchronous, active high) returns the parser to waiting for a record start,
// empties the queue and output register, and clears both configuration registers.
module sprite_run_length_decoder #(
  parameter int unsigned FRAME_PIXELS = srld_pkg::FRAME_PIXELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [srld_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srld_pkg::CFG_DATA_W-1:0]  cfg_data,
  srld_byte_if.sink                        in_ch,
  srld_pixel_if.source                     out_ch
);
  import srld_pkg::*;

  logic blue_first_order;
  logic alpha_in_stream;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic full;
  logic not_empty;
  cmd_t head;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blue_first_order <= 1'b0;
      alpha_in_stream  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLUE_FIRST: blue_first_order <= cfg_data[0];
        CFG_ALPHA_IN:   alpha_in_stream  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  srld_parse #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) u_parse (
    .clk            (clk),
    .rst            (rst),
    .alpha_in_stream(alpha_in_stream),
    .queue_full     (full),
    .in_ch          (in_ch),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  srld_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .not_empty(not_empty),
    .head     (head)
  );

  srld_pack u_pack (
    .clk             (clk),
    .rst             (rst),
    .blue_first_order(blue_first_order),
    .not_empty       (not_empty),
    .head            (head),
    .pop             (pop),
    .out_ch          (out_ch)
  );

endmodule

### src/srld_checker.sv
// Port-level checks for the sprite run-length decoder, bound to the top level.
module srld_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        pixel_valid,
  input logic [9:0]  pixel_index,
  input logic [31:0] pixel_word,
  input logic        record_done
);

  // A stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_index) && $stable(pixel_word)
      && $stable(pixel_valid) && $stable(record_done))
    else $error("stalled result changed");

  // Every result carries a pixel or a record end
  a_not_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pixel_valid || record_done)
    else $error("result with neither pixel nor done");

  // A done-only result has zeroed pixel fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pixel_valid |-> pixel_index == 10'd0 && pixel_word == 32'd0)
    else $error("pixel fields not zero on done-only result");

  // Nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind sprite_run_length_decoder srld_checker u_srld_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .pixel_valid(out_ch.pixel_valid),
  .pixel_index(out_ch.pixel_index),
  .pixel_word (out_ch.pixel_word),
  .record_done(out_ch.record_done)
);

### sim/sprite_run_length_decoder_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sprite run-length decoder with its own decoder model.
module sprite_run_length_decoder_test;
  import srld_pkg::*;

  localparam int FRAME = FRAME_PIXELS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 40;

  typedef enum logic [3:0] {
    DEC_IDLE, DEC_KEY1, DEC_KEY2, DEC_SIZE_LO, DEC_SIZE_HI,
    DEC_SKIP_LO, DEC_SKIP_HI, DEC_COUNT_LO, DEC_COUNT_HI, DEC_PIXEL
  } dec_phase_t;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;
  typedef enum {SZ_EXACT, SZ_SHORT, SZ_LONG, SZ_ZERO} size_mode_t;

  typedef struct packed {
    logic                 pixel_valid;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [31:0]          pixel_word;
    logic                 record_done;
  } pixel_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } stream_byte_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  srld_byte_if  in_ch();
  srld_pixel_if out_ch();

  sprite_run_length_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Decoder model state and configuration
  dec_phase_t  dec_phase;
  logic [15:0] dec_size;
  logic [16:0] dec_consumed;
  logic [10:0] dec_pos;
  logic [15:0] dec_left;
  logic [7:0]  dec_low;
  logic [23:0] dec_colour;
  logic [1:0]  dec_ccount;
  logic        cfg_bgr;
  logic        cfg_alpha;

  pixel_result_t predicted_pixels[$];
  stream_byte_t  record_bytes[$];
  pixel_result_t head;

  int errors = 0;
  int cycles = 0;
  int took_bytes = 0;
  int burst_left = 0;
  int gap_max = 0;
  int gap_choices[4] = '{0, 1, 4, 9};

  rx_mode_t   rx_mode = RX_RANDOM;
  logic [7:0] rx_pattern = 8'hB5;
  int         rx_tick = 0;
  int         hold_len = 0;
  int         hold_seq = 0;
  int         hold_seen = 0;
  int         hold_count = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sprite_run_length_decoder");
      $finish;
    end
  end

  // Model: count saturating payload bytes
  function automatic void add_consumed(input int unsigned n);
    logic [17:0] sum;
    sum = 18'(dec_consumed) + 18'(n);
    dec_consumed = (sum > 18'h1FFFF) ? 17'h1FFFF : sum[16:0];
  endfunction

  // Model: at a run boundary either finish the record or expect the next run
  function automatic logic end_of_run();
    if (dec_consumed >= 17'(dec_size)) begin
      dec_phase = DEC_IDLE;
      return 1'b1;
    end
    dec_phase = DEC_SKIP_LO;
    return 1'b0;
  endfunction

  // Model: advance by one accepted byte and record the result it causes
  function automatic void decode_byte(input logic [7:0] b, input logic start);
    pixel_result_t r;
    logic [1:0]    c;
    logic          complete;
    logic          fin;
    logic [7:0]    a;
    logic [16:0]   np;
    r = '0;
    complete = 1'b0;
    fin = 1'b0;
    a = 8'hFF;
    c = dec_ccount;
    if (start || dec_phase != DEC_IDLE) took_bytes++;
    if (start) begin
      dec_size = '0;
      dec_consumed = '0;
      dec_pos = '0;
      dec_left = '0;
      dec_low = '0;
      dec_colour = '0;
      dec_ccount = '0;
      dec_phase = DEC_KEY1;
    end else begin
      case (dec_phase)
        DEC_IDLE: ;
        DEC_KEY1: dec_phase = DEC_KEY2;
        DEC_KEY2: dec_phase = DEC_SIZE_LO;
        DEC_SIZE_LO: begin
          dec_low = b;
          dec_phase = DEC_SIZE_HI;
        end
        DEC_SIZE_HI: begin
          dec_size = {b, dec_low};
          if (dec_size == 16'd0) begin
            fin = 1'b1;
            dec_phase = DEC_IDLE;
          end else begin
            dec_phase = DEC_SKIP_LO;
          end
        end
        DEC_SKIP_LO: begin
          dec_low = b;
          dec_phase = DEC_SKIP_HI;
        end
        DEC_SKIP_HI: begin
          np = 17'(dec_pos) + 17'({b, dec_low});
          dec_pos = (np > 17'(FRAME)) ? 11'(FRAME) : np[10:0];
          dec_phase = DEC_COUNT_LO;
        end
        DEC_COUNT_LO: begin
          dec_low = b;
          dec_phase = DEC_COUNT_HI;
        end
        DEC_COUNT_HI: begin
          dec_left = {b, dec_low};
          add_consumed(4);
          dec_ccount = '0;
          dec_colour = '0;
          if (dec_left == 16'd0) fin = end_of_run();
          else dec_phase = DEC_PIXEL;
        end
        DEC_PIXEL: begin
          // Alpha setting is looked at on the third colour byte
          if (c != 2'd3) begin
            dec_colour = dec_colour | (24'(b) << (8 * c));
            if (c == 2'd2 && !cfg_alpha) complete = 1'b1;
            else dec_ccount = c + 2'd1;
          end else begin
            a = b;
            complete = 1'b1;
          end
          if (complete) begin
            add_consumed((c == 2'd3) ? 4 : 3);
            // Pixels past the frame are consumed silently
            if (dec_pos < 11'(FRAME)) begin
              r.pixel_valid = 1'b1;
              r.pixel_index = dec_pos[PIX_IDX_W-1:0];
              r.pixel_word = cfg_bgr ?
                {a, dec_colour[7:0], dec_colour[15:8], dec_colour[23:16]} :
                {a, dec_colour[23:16], dec_colour[15:8], dec_colour[7:0]};
              dec_pos = dec_pos + 11'd1;
            end
            dec_colour = '0;
            dec_ccount = '0;
            dec_left = dec_left - 16'd1;
            if (dec_left == 16'd0) fin = end_of_run();
          end
        end
        default: dec_phase = DEC_IDLE;
      endcase
    end
    r.record_done = fin;
    if (r.pixel_valid || fin) predicted_pixels.push_back(r);
  endfunction

  // Send one byte: bursts of random length with random gaps in between
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.record_start <= start;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, start);
  endtask

  function automatic void push_byte(input logic [7:0] b, input logic start);
    stream_byte_t it;
    it.data = b;
    it.start = start;
    record_bytes.push_back(it);
  endfunction

  function automatic void push_header(input logic [15:0] size);
    push_byte(8'($urandom), 1'b1);
    push_byte(8'($urandom), 1'b0);
    push_byte(8'($urandom), 1'b0);
    push_byte(size[7:0], 1'b0);
    push_byte(size[15:8], 1'b0);
  endfunction

  function automatic void push_run_head(input logic [15:0] skip, input logic [15:0] count);
    push_byte(skip[7:0], 1'b0);
    push_byte(skip[15:8], 1'b0);
    push_byte(count[7:0], 1'b0);
    push_byte(count[15:8], 1'b0);
  endfunction

  task automatic flush_bytes();
    stream_byte_t it;
    while (record_bytes.size() > 0) begin
      it = record_bytes.pop_front();
      send_byte(it.data, it.start);
    end
  endtask

  // Build one record with random content; the size field may disagree with the runs
  task automatic queue_record(input int n_runs, input int max_pix, input bit wide,
                              input size_mode_t size_mode);
    int unsigned skips[$];
    int unsigned counts[$];
    int unsigned total;
    int unsigned sz;
    int unsigned bpp;
    int r;
    int p;
    total = 0;
    bpp = cfg_alpha ? 4 : 3;
    for (r = 0; r < n_runs; r++) begin
      if (!wide) skips.push_back($urandom_range(0, 24));
      else if ($urandom_range(0, 3) == 0) skips.push_back($urandom_range(0, 65535));
      else skips.push_back($urandom_range(1000, 1030));
      counts.push_back($urandom_range(0, max_pix));
      total += 4 + counts[r] * bpp;
    end
    case (size_mode)
      SZ_SHORT: sz = $urandom_range(1, total);
      SZ_LONG:  sz = total + $urandom_range(1, 64);
      SZ_ZERO:  sz = 0;
      default:  sz = total;
    endcase
    push_header(16'(sz));
    for (r = 0; r < n_runs; r++) begin
      push_run_head(16'(skips[r]), 16'(counts[r]));
      for (p = 0; p < counts[r] * bpp; p++) push_byte(8'($urandom), 1'b0);
    end
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (predicted_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BLUE_FIRST) cfg_bgr = val;
    else cfg_alpha = val;
  endtask

  task automatic configure(input logic bgr, input logic alpha);
    settle();
    set_reg(CFG_BLUE_FIRST, bgr);
    set_reg(CFG_ALPHA_IN, alpha);
  endtask

  // Receiver: long hold-off on request, otherwise the current stall pattern
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_count = hold_len;
      end
      if (hold_count > 0) begin
        hold_count--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  out_ch.ready <= 1'b1;
          RX_RANDOM:  out_ch.ready <= ($urandom_range(0, 9) < 7);
          RX_PATTERN: out_ch.ready <= rx_pattern[rx_tick % 8];
          default:    out_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
      rx_tick++;
    end
  end

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // Check every result transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (predicted_pixels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %b %h %h %b", $time,
                   out_ch.pixel_valid, out_ch.pixel_index, out_ch.pixel_word,
                   out_ch.record_done);
      end else begin
        head = predicted_pixels.pop_front();
        report("pixel_valid", 32'(head.pixel_valid), 32'(out_ch.pixel_valid));
        report("pixel_index", 32'(head.pixel_index), 32'(out_ch.pixel_index));
        report("pixel_word", head.pixel_word, out_ch.pixel_word);
        report("record_done", 32'(head.record_done), 32'(out_ch.record_done));
      end
    end
  end

  // Bytes outside a record are ignored
  task automatic test_ignored_bytes();
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    flush_bytes();
  endtask

  // Record with an empty payload finishes on its second size byte
  task automatic test_zero_size();
    push_header(16'h0000);
    flush_bytes();
  endtask

  // Both byte orders, with and without alpha, first and last frame index
  task automatic test_pixel_formats();
    configure(1'b0, 1'b0);
    push_header(16'd10);
    push_run_head(16'd0, 16'd2);
    repeat (3) push_byte(8'h00, 1'b0);
    repeat (3) push_byte(8'hFF, 1'b0);
    flush_bytes();
    configure(1'b1, 1'b1);
    push_header(16'd8);
    push_run_head(16'd1023, 16'd1);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'h00, 1'b0);
    flush_bytes();
  endtask

  // Empty run, saturating skip, and a pixel dropped past the frame end
  task automatic test_empty_run_overflow();
    configure(1'b0, 1'b0);
    push_header(16'd11);
    push_run_head(16'hFFFF, 16'd0);
    push_run_head(16'h0001, 16'd1);
    repeat (3) push_byte(8'($urandom), 1'b0);
    flush_bytes();
  endtask

  // A new start abandons the record in progress
  task automatic test_restart_mid_record();
    push_header(16'h0020);
    push_run_head(16'd0, 16'd3);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_header(16'h0000);
    flush_bytes();
  endtask

  // Turning alpha off with three colour bytes held takes the next byte as alpha
  task automatic test_alpha_switch();
    configure(1'b0, 1'b1);
    push_header(16'd8);
    push_run_head(16'd5, 16'd1);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);
    flush_bytes();
    settle();
    set_reg(CFG_ALPHA_IN, 1'b0);
    push_byte(8'h80, 1'b0);
    flush_bytes();
  endtask

  // Hold the receiver off while a long run streams in, so the input stalls
  task automatic test_backpressure();
    configure(1'b0, 1'b0);
    gap_max = 0;
    rx_mode = RX_ALWAYS;
    @(posedge clk);
    hold_len = 300;
    hold_seq++;
    push_header(16'(4 + 260 * 3));
    push_run_head(16'd900, 16'd260);
    repeat (260 * 3) push_byte(8'($urandom), 1'b0);
    flush_bytes();
  endtask

  // Mostly well-formed records, with truncated, mis-sized and noisy streams mixed in
  task automatic test_random_traffic(input int phases, input int per_phase);
    int ph;
    int first;
    int kind;
    int keep;
    int n;
    for (ph = 0; ph < phases; ph++) begin
      if (ph < 4) configure(ph[0], ph[1]);
      else configure(1'($urandom), 1'($urandom));
      if (ph == 0) begin
        gap_max = 0;
        rx_mode = RX_ALWAYS;
      end else begin
        gap_max = gap_choices[$urandom_range(0, 3)];
        rx_mode = rx_mode_t'(ph % 4);
        rx_pattern = 8'($urandom_range(1, 255));
      end
      first = took_bytes;
      while (took_bytes - first < per_phase) begin
        kind = $urandom_range(0, 99);
        if (kind < 62) begin
          queue_record($urandom_range(1, 4), 5, ($urandom_range(0, 9) == 0), SZ_EXACT);
        end else if (kind < 72) begin
          queue_record($urandom_range(1, 3), 4, 1'b0, SZ_EXACT);
          keep = $urandom_range(1, record_bytes.size() - 1);
          while (record_bytes.size() > keep) void'(record_bytes.pop_back());
        end else if (kind < 80) begin
          queue_record($urandom_range(2, 4), 4, 1'b0, SZ_SHORT);
        end else if (kind < 85) begin
          queue_record($urandom_range(1, 2), 4, 1'b0, SZ_LONG);
        end else if (kind < 89) begin
          queue_record(1, 2, 1'b0, SZ_ZERO);
        end else begin
          n = $urandom_range(4, 16);
          repeat (n) push_byte(8'($urandom), ($urandom_range(0, 7) == 0));
        end
        flush_bytes();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.record_start = 1'b0;
    dec_phase = DEC_IDLE;
    dec_size = '0;
    dec_consumed = '0;
    dec_pos = '0;
    dec_left = '0;
    dec_low = '0;
    dec_colour = '0;
    dec_ccount = '0;
    cfg_bgr = 1'b0;
    cfg_alpha = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    gap_max = 2;
    rx_mode = RX_RANDOM;
    test_ignored_bytes();
    test_zero_size();
    test_pixel_formats();
    test_empty_run_overflow();
    test_restart_mid_record();
    test_alpha_switch();
    test_backpressure();
    test_random_traffic(11, 70);

    settle();
    if (errors == 0) begin
      $display("PASS sprite_run_length_decoder");
    end else begin
      $display("FAIL sprite_run_length_decoder");
    end
    $finish;
  end

endmodule

### sim.f
src/srld_pkg.sv
src/srld_if.sv
src/srld_parse.sv
src/srld_queue.sv
src/srld_pack.sv
src/sprite_run_length_decoder.sv
src/srld_checker.sv
sim/sprite_run_length_decoder_test.sv
